FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define NPE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define NPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/npe_pkg.sv
package npe_pkg;

   localparam int MAX_LEN_DEF    = 16;
   localparam int ELEM_WIDTH_DEF = 8;

   localparam int INDEX_W = 4;
   localparam int VALUE_W = 8;
   localparam int LEN_W   = 5;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [INDEX_W-1:0] elem_index;
      logic [VALUE_W-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] out_value;
      logic               found;
      logic               last;
   } rsp_type;

   // Result control, registered alongside the store's read data.
   typedef struct packed {
      logic strobe;
      logic found;
      logic last;
      logic marker;
   } rsp_ctl_type;

endpackage

FILE: sv/npe_ram.sv
module npe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/npe_ctrl.sv
module npe_ctrl #(
   parameter int MAX_LEN    = 16,
   parameter int ELEM_WIDTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  npe_pkg::req_type             req,
   input  logic [npe_pkg::LEN_W-1:0]    seq_len,
   output logic                         ram_we,
   output logic [$clog2(MAX_LEN)-1:0]   ram_waddr,
   output logic [ELEM_WIDTH-1:0]        ram_wdata,
   output logic                         ram_re,
   output logic [$clog2(MAX_LEN)-1:0]   ram_raddr,
   input  logic [ELEM_WIDTH-1:0]        ram_rdata,
   output npe_pkg::rsp_ctl_type         rsp_ctl
);

   import npe_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int PW = AW + 1;
   localparam int LW = $clog2(MAX_LEN + 1);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_PIV_INIT  = 11'b000_0000_0010,
      ST_PIV_SCAN  = 11'b000_0000_0100,
      ST_SUC_INIT  = 11'b000_0000_1000,
      ST_SUC_SCAN  = 11'b000_0001_0000,
      ST_SWAP_P    = 11'b000_0010_0000,
      ST_REV_RD_LO = 11'b000_0100_0000,
      ST_REV_RD_HI = 11'b000_1000_0000,
      ST_REV_WR_LO = 11'b001_0000_0000,
      ST_REV_WR_HI = 11'b010_0000_0000,
      ST_EMIT      = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]         cur_ff, cur_in;
   logic [AW-1:0]         piv_ff, piv_in;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [AW-1:0]         em_ff, em_in;
   logic [AW-1:0]         nm1_ff, nm1_in;
   logic [ELEM_WIDTH-1:0] prev_ff, prev_in;
   logic [ELEM_WIDTH-1:0] pv_ff, pv_in;
   logic [ELEM_WIDTH-1:0] kv_ff, kv_in;
   logic [ELEM_WIDTH-1:0] lv_ff, lv_in;
   logic                  first_ff, first_in;
   logic                  found_ff, found_in;
   rsp_ctl_type           rsp_ctl_ff, rsp_ctl_in;

   logic [LW-1:0]         len_clamp;
   logic [AW-1:0]         len_nm1;
   logic                  idx_ok;
   logic [ELEM_WIDTH-1:0] cmp_a, cmp_b;
   logic                  cmp_lt;

   // A length above the store depth acts as the full depth.
   always_comb begin
      len_clamp = (32'(seq_len) > 32'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(seq_len);
      len_nm1   = AW'(len_clamp - LW'(1));
      idx_ok    = 32'(req.elem_index) < 32'(MAX_LEN);
   end

   // Shared magnitude comparator for both scans.
   always_comb begin
      if (state_ff == ST_PIV_SCAN) begin
         cmp_a = ram_rdata;
         cmp_b = prev_ff;
      end else begin
         cmp_a = pv_ff;
         cmp_b = ram_rdata;
      end
      cmp_lt = cmp_a < cmp_b;
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      piv_in     = piv_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      em_in      = em_ff;
      nm1_in     = nm1_ff;
      prev_in    = prev_ff;
      pv_in      = pv_ff;
      kv_in      = kv_ff;
      lv_in      = lv_ff;
      first_in   = first_ff;
      found_in   = found_ff;
      rsp_ctl_in = '0;
      ram_we     = 1'b0;
      ram_waddr  = cur_ff;
      ram_wdata  = pv_ff;
      ram_re     = 1'b0;
      ram_raddr  = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req.operation == OP_LOAD) begin
                  // drop loads beyond the store depth
                  ram_we    = idx_ok;
                  ram_waddr = AW'(req.elem_index);
                  ram_wdata = ELEM_WIDTH'(req.elem_value);
               end else begin
                  found_in = 1'b0;
                  nm1_in   = len_nm1;
                  em_in    = '0;
                  if (len_clamp == '0) begin
                     rsp_ctl_in.strobe = 1'b1;
                     rsp_ctl_in.last   = 1'b1;
                     rsp_ctl_in.marker = 1'b1;
                  end else if (len_clamp == LW'(1)) begin
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_PIV_INIT;
                  end
               end
            end
         end
         ST_PIV_INIT: begin
            ram_re    = 1'b1;
            ram_raddr = nm1_ff;
            cur_in    = nm1_ff;
            first_in  = 1'b1;
            state_in  = ST_PIV_SCAN;
         end
         ST_PIV_SCAN: begin
            if (!first_ff && cmp_lt) begin
               piv_in   = cur_ff;
               pv_in    = ram_rdata;
               state_in = ST_SUC_INIT;
            end else begin
               prev_in  = ram_rdata;
               first_in = 1'b0;
               if (cur_ff == '0) begin
                  // no ascent: last permutation, emit unchanged
                  em_in    = '0;
                  state_in = ST_EMIT;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = cur_ff - AW'(1);
                  cur_in    = cur_ff - AW'(1);
               end
            end
         end
         ST_SUC_INIT: begin
            ram_re    = 1'b1;
            ram_raddr = nm1_ff;
            cur_in    = nm1_ff;
            state_in  = ST_SUC_SCAN;
         end
         ST_SUC_SCAN: begin
            if (cmp_lt) begin
               // rightmost larger element: write the pivot into its slot
               ram_we    = 1'b1;
               ram_waddr = cur_ff;
               ram_wdata = pv_ff;
               kv_in     = ram_rdata;
               state_in  = ST_SWAP_P;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = cur_ff - AW'(1);
               cur_in    = cur_ff - AW'(1);
            end
         end
         ST_SWAP_P: begin
            ram_we    = 1'b1;
            ram_waddr = piv_ff;
            ram_wdata = kv_ff;
            found_in  = 1'b1;
            lo_in     = piv_ff + AW'(1);
            hi_in     = nm1_ff;
            em_in     = '0;
            if (({1'b0, piv_ff} + PW'(1)) < {1'b0, nm1_ff}) begin
               state_in = ST_REV_RD_LO;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_REV_RD_LO: begin
            ram_re    = 1'b1;
            ram_raddr = lo_ff;
            state_in  = ST_REV_RD_HI;
         end
         ST_REV_RD_HI: begin
            ram_re    = 1'b1;
            ram_raddr = hi_ff;
            lv_in     = ram_rdata;
            state_in  = ST_REV_WR_LO;
         end
         ST_REV_WR_LO: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = ram_rdata;
            state_in  = ST_REV_WR_HI;
         end
         ST_REV_WR_HI: begin
            ram_we    = 1'b1;
            ram_waddr = hi_ff;
            ram_wdata = lv_ff;
            lo_in     = lo_ff + AW'(1);
            hi_in     = hi_ff - AW'(1);
            if (({1'b0, lo_ff} + PW'(2)) < {1'b0, hi_ff}) begin
               state_in = ST_REV_RD_LO;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            ram_re            = 1'b1;
            ram_raddr         = em_ff;
            rsp_ctl_in.strobe = 1'b1;
            rsp_ctl_in.found  = found_ff;
            rsp_ctl_in.last   = (em_ff == nm1_ff);
            em_in             = em_ff + AW'(1);
            if (em_ff == nm1_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_ctl_ff <= '0;
         found_ff   <= 1'b0;
         first_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_ctl_ff <= rsp_ctl_in;
         found_ff   <= found_in;
         first_ff   <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      piv_ff  <= piv_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      em_ff   <= em_in;
      nm1_ff  <= nm1_in;
      prev_ff <= prev_in;
      pv_ff   <= pv_in;
      kv_ff   <= kv_in;
      lv_ff   <= lv_in;
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rsp_ctl = rsp_ctl_ff;

endmodule

FILE: sv/next_permutation_engine_top.sv
// Channel   Ports                                 Direction  Transfer
// request   start, busy, req_data                 in         start high, busy low
// result    rsp_valid, rsp_data                   out        rsp_valid high
// config    csr_write_en, csr_write_data          in         write enable high
//
// A load gives no result.
// An advance runs two scans and the swap, then per reversed pair reads low and high
// and writes low and high, then gives one result per cycle, all paced by the single
// read port of the sequence store.
// Reset clears the length register and the sequencer; the store is not cleared.
// Results cannot be stalled: they leave one per cycle in order.
`include "assert_macros.svh"

module next_permutation_engine_top #(
   parameter int MAX_LEN    = npe_pkg::MAX_LEN_DEF,
   parameter int ELEM_WIDTH = npe_pkg::ELEM_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  npe_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output npe_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_en,
   input  logic [npe_pkg::LEN_W-1:0] csr_write_data
);

   import npe_pkg::*;

   localparam int AW = $clog2(MAX_LEN);

   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;
   rsp_ctl_type           ctl;

   always_comb begin
      len_in = csr_write_en ? csr_write_data : len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   npe_ctrl #(
      .MAX_LEN    (MAX_LEN),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_data),
      .seq_len   (len_ff),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_ctl   (ctl)
   );

   npe_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The empty marker carries a zero value instead of store data.
   always_comb begin
      rsp_valid          = ctl.strobe;
      rsp_data.out_value = ctl.marker ? '0 : VALUE_W'(ram_rdata);
      rsp_data.found     = ctl.found;
      rsp_data.last      = ctl.last;
   end

   `NPE_ASSERT_NOW(a_marker_final, clock, reset, rsp_valid && ctl.marker,
      rsp_data.last && !rsp_data.found, "empty marker must be final and not found")

   `NPE_ASSERT_NEXT(a_advance_starts, clock, reset,
      start && !busy && (req_data.operation == OP_ADVANCE),
      busy || rsp_valid, "advance transfer neither started work nor gave a marker")

   `NPE_ASSERT_NEXT(a_load_silent, clock, reset,
      start && !busy && (req_data.operation == OP_LOAD),
      !rsp_valid, "load transfer produced a result")

endmodule
